[rtl/afu_pkg.sv]
// Package for the ASCII1 field unescape block: item structs, phase and
// result-kind codes, character constants and the hex digit decoder.
// No dependencies.
package afu_pkg;

    localparam logic [7:0] CH_OPEN   = 8'h7B;  // '{'
    localparam logic [7:0] CH_CLOSE  = 8'h7D;  // '}'
    localparam logic [7:0] CH_BSLASH = 8'h5C;  // backslash

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_FIELD = 3'd1,
        PH_ESC1  = 3'd2,
        PH_ESC2  = 3'd3,
        PH_SKIP  = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        K_DATA   = 2'd0,
        K_DONE   = 2'd1,
        K_NOOPEN = 2'd2,
        K_BADHEX = 2'd3
    } t_kind;

    typedef struct packed {
        logic [7:0] char_in;
        logic [7:0] capacity;
    } t_in_item;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data_byte;
        logic [7:0] byte_count;
        logic       last;
    } t_out_item;

    typedef struct packed {
        t_phase     phase;
        logic [3:0] high_nibble;
        logic [7:0] stored_count;
        logic [7:0] limit;
    } t_state;

    typedef struct packed {
        logic       ok;
        logic [3:0] nibble;
    } t_hex;

    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex h;
        h.ok     = 1'b1;
        h.nibble = 4'h0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.nibble = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.nibble = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.nibble = 4'(c - 8'h37);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

[rtl/ascii1_field_unescape_core.sv]
// Top level of the ASCII1 field unescape block: field state register, decode
// step and a two-entry output buffer. Depends on afu_pkg and afu_step.
//
// Decodes one brace-delimited ASCII1 field, one character per input item.
// Each accepted character updates the field state in the same cycle and
// gives at most one result item (data byte, field done, missing open brace
// or bad hex escape); the result is registered in the result register, or in
// the skid register while the output stalls. The block takes one character
// per clock while the skid register is free. The output side has a result
// register and a skid register; o_in_stall rises only when the skid register
// holds an item, so it is a registered signal and never depends on i_in_valid.
// capacity is sampled only at the opening brace and is clamped to the range
// 1..MAX_FIELD_SIZE (and never beyond 255); the clamped limit less one bytes can be stored.
module ascii1_field_unescape_core #(
    parameter int unsigned MAX_FIELD_SIZE = 255
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // character input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  afu_pkg::t_in_item  i_in_item,
    // result output channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output afu_pkg::t_out_item o_out_item
);

    // Field state and its next value.
    afu_pkg::t_state    r_state;
    afu_pkg::t_state    n_state;

    // Step outputs.
    logic               step_emit;
    afu_pkg::t_out_item step_res;

    // Output buffer: result register plus skid register.
    logic               r_out_vld;
    afu_pkg::t_out_item r_out;
    logic               r_skd_vld;
    afu_pkg::t_out_item r_skd;

    logic               in_acc;
    logic               res_vld;
    logic               out_pop;

    // Take a character whenever the skid register is free.
    assign o_in_stall = r_skd_vld;
    assign in_acc     = i_in_valid && !r_skd_vld;
    assign res_vld    = in_acc && step_emit;
    assign out_pop    = r_out_vld && !i_out_stall;

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    afu_step #(
        .MAX_FIELD_SIZE(MAX_FIELD_SIZE)
    ) u_step (
        .i_cur  (r_state),
        .i_item (i_in_item),
        .o_nxt  (n_state),
        .o_emit (step_emit),
        .o_res  (step_res)
    );

    // Advance the field state only on an accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: afu_pkg::PH_IDLE, high_nibble: 4'h0,
                         stored_count: 8'h00, limit: 8'h00};
        end else if (in_acc) begin
            r_state <= n_state;
        end
    end

    // Output buffer control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_skd_vld <= 1'b0;
        end else if (!r_out_vld || out_pop) begin
            // Result register frees up: refill from the skid first, else
            // from the step (no item is taken while the skid is full).
            if (r_skd_vld) begin
                r_out_vld <= 1'b1;
                r_skd_vld <= 1'b0;
            end else begin
                r_out_vld <= res_vld;
            end
        end else if (res_vld) begin
            // Result register held by the stall: park the new result.
            r_skd_vld <= 1'b1;
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge i_clk) begin
        if (!r_out_vld || out_pop) begin
            r_out <= r_skd_vld ? r_skd : step_res;
        end
        if (r_out_vld && !out_pop && res_vld) begin
            r_skd <= step_res;
        end
    end

    // The skid register is only ever filled behind a full result register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skd_vld |-> r_out_vld)
        else $error("skid holds an item while the result register is empty");

    // Inside a field the stored count stays below the limit less one.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == afu_pkg::PH_FIELD || r_state.phase == afu_pkg::PH_ESC1 ||
         r_state.phase == afu_pkg::PH_ESC2)
        |-> (({1'b0, r_state.stored_count} + 9'd1) < {1'b0, r_state.limit}))
        else $error("stored count reached the field limit outside skip");

    // A missing-brace result ends the field and carries a zero count.
    a_noopen_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.kind == afu_pkg::K_NOOPEN)
        |-> (r_out.last && r_out.byte_count == 8'h00 && r_out.data_byte == 8'h00))
        else $error("missing-brace result malformed");

endmodule

[rtl/afu_step.sv]
// Per-character decode step: next field state and the optional result item.
// Purely combinational; depends on afu_pkg.
module afu_step #(
    parameter int unsigned MAX_FIELD_SIZE = 255
) (
    input  afu_pkg::t_state    i_cur,
    input  afu_pkg::t_in_item  i_item,
    output afu_pkg::t_state    o_nxt,
    output logic               o_emit,
    output afu_pkg::t_out_item o_res
);

    localparam logic [7:0] CapMax = (MAX_FIELD_SIZE > 255) ? 8'd255 : 8'(MAX_FIELD_SIZE);

    afu_pkg::t_hex hex;
    logic          do_store;
    logic [7:0]    store_byte;
    logic [7:0]    cnt_inc;
    logic [7:0]    cap_lo;

    always_comb begin
        hex        = afu_pkg::hex_decode(i_item.char_in);
        o_nxt      = i_cur;
        o_emit     = 1'b0;
        o_res      = '{kind: afu_pkg::K_DATA, data_byte: 8'h00,
                       byte_count: i_cur.stored_count, last: 1'b0};
        do_store   = 1'b0;
        store_byte = i_item.char_in;
        cap_lo     = (i_item.capacity == 8'h00) ? 8'h01 : i_item.capacity;
        cnt_inc    = i_cur.stored_count + 8'd1;

        unique case (i_cur.phase)
            afu_pkg::PH_FIELD: begin
                if (i_item.char_in == afu_pkg::CH_CLOSE) begin
                    o_nxt.phase = afu_pkg::PH_IDLE;
                    o_emit      = 1'b1;
                    o_res.kind  = afu_pkg::K_DONE;
                    o_res.last  = 1'b1;
                end else if (i_item.char_in == afu_pkg::CH_BSLASH) begin
                    o_nxt.phase = afu_pkg::PH_ESC1;
                end else begin
                    do_store = 1'b1;
                end
            end
            afu_pkg::PH_ESC1: begin
                if (i_item.char_in == afu_pkg::CH_BSLASH) begin
                    do_store = 1'b1;
                end else if (!hex.ok) begin
                    o_nxt.phase = afu_pkg::PH_IDLE;
                    o_emit      = 1'b1;
                    o_res.kind  = afu_pkg::K_BADHEX;
                    o_res.last  = 1'b1;
                end else begin
                    o_nxt.high_nibble = hex.nibble;
                    o_nxt.phase       = afu_pkg::PH_ESC2;
                end
            end
            afu_pkg::PH_ESC2: begin
                do_store   = 1'b1;
                // A non-hex second character is swallowed; keep the lone digit.
                store_byte = hex.ok ? {i_cur.high_nibble, hex.nibble}
                                    : {4'h0, i_cur.high_nibble};
            end
            afu_pkg::PH_SKIP: begin
                if (i_item.char_in == afu_pkg::CH_CLOSE) begin
                    o_nxt.phase = afu_pkg::PH_IDLE;
                    o_emit      = 1'b1;
                    o_res.kind  = afu_pkg::K_DONE;
                    o_res.last  = 1'b1;
                end
            end
            default: begin
                o_nxt.phase        = afu_pkg::PH_IDLE;
                o_nxt.stored_count = 8'h00;
                if (i_item.char_in != afu_pkg::CH_OPEN) begin
                    o_emit           = 1'b1;
                    o_res.kind       = afu_pkg::K_NOOPEN;
                    o_res.byte_count = 8'h00;
                    o_res.last       = 1'b1;
                end else begin
                    o_nxt.limit       = (cap_lo > CapMax) ? CapMax : cap_lo;
                    o_nxt.high_nibble = 4'h0;
                    o_nxt.phase       = (o_nxt.limit <= 8'd1) ? afu_pkg::PH_SKIP
                                                              : afu_pkg::PH_FIELD;
                end
            end
        endcase

        if (do_store) begin
            o_nxt.stored_count = cnt_inc;
            o_nxt.phase = (({1'b0, cnt_inc} + 9'd1) >= {1'b0, i_cur.limit})
                          ? afu_pkg::PH_SKIP : afu_pkg::PH_FIELD;
            o_emit           = 1'b1;
            o_res.kind       = afu_pkg::K_DATA;
            o_res.data_byte  = store_byte;
            o_res.byte_count = cnt_inc;
        end
    end

endmodule

[tb/ascii1_field_unescape_core_tb.sv]
// Testbench for ascii1_field_unescape_core: drives character items, predicts
// every result item with an in-house field decoder and checks each one.
// Depends on afu_pkg and the core RTL only.
`timescale 1ns / 100ps

module ascii1_field_unescape_core_tb;

    localparam int MAX_FIELD          = 255;
    localparam int CLK_HALF           = 4;
    localparam int RESET_CYCLES       = 9;
    localparam int RANDOM_ITEMS       = 2000;
    localparam int CYCLE_LIMIT        = 200000;
    localparam int DRAIN_LIMIT        = 2000;
    localparam int TAIL_CYCLES        = 10;
    localparam int MAX_PRINTED_ERRORS = 30;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    afu_pkg::t_in_item  i_in_item;
    logic               o_out_valid;
    logic               i_out_stall;
    afu_pkg::t_out_item o_out_item;

    // Field decoder state, mirrored from the block's behavior
    afu_pkg::t_phase fld_phase;
    logic [3:0]      fld_nibble;
    logic [7:0]      fld_count;
    logic [7:0]      fld_limit;

    // Result items still owed by the block, oldest first
    afu_pkg::t_out_item expected_results[$];

    int  error_count;
    int  sent_items;
    int  results_seen;
    int  fields_done;
    int  field_errors;
    int  cycle_count;
    bit  idle_on;      // random gaps and stalls enabled
    int  rx_wait;      // stall cycles drawn for the next result item
    int  stall_hold;   // long receiver hold-off, counted down below

    ascii1_field_unescape_core #(
        .MAX_FIELD_SIZE (MAX_FIELD)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Cycle counter and watchdog: end the run if it ever hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("TIMEOUT after %0d cycles, %0d result items outstanding",
                 cycle_count, expected_results.size());
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Return the hex value of a character, or -1 when it is no hex digit.
    function automatic int hex_nibble(logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
        if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
        if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
        return -1;
    endfunction

    function automatic void push_result(afu_pkg::t_kind kind, logic [7:0] data,
                                        logic last);
        afu_pkg::t_out_item r;
        r.kind       = kind;
        r.data_byte  = data;
        r.byte_count = fld_count;
        r.last       = last;
        expected_results.push_back(r);
    endfunction

    // Store one decoded byte; move to skip once only the terminator slot is left.
    function automatic void store_byte(logic [7:0] data);
        fld_count = fld_count + 8'd1;
        fld_phase = (int'(fld_count) + 1 >= int'(fld_limit)) ? afu_pkg::PH_SKIP
                                                             : afu_pkg::PH_FIELD;
        push_result(afu_pkg::K_DATA, data, 1'b0);
    endfunction

    // Advance the decoder by one accepted character.
    function automatic void predict_char(logic [7:0] c, logic [7:0] cap);
        int nib;
        int lim;
        nib = hex_nibble(c);
        case (fld_phase)
            afu_pkg::PH_FIELD: begin
                if (c == afu_pkg::CH_CLOSE) begin
                    fld_phase = afu_pkg::PH_IDLE;
                    push_result(afu_pkg::K_DONE, 8'h00, 1'b1);
                end else if (c == afu_pkg::CH_BSLASH) begin
                    fld_phase = afu_pkg::PH_ESC1;
                end else begin
                    store_byte(c);
                end
            end
            afu_pkg::PH_ESC1: begin
                if (c == afu_pkg::CH_BSLASH) begin
                    store_byte(c);
                end else if (nib < 0) begin
                    // Bad first digit ends the field
                    fld_phase = afu_pkg::PH_IDLE;
                    push_result(afu_pkg::K_BADHEX, 8'h00, 1'b1);
                end else begin
                    fld_nibble = 4'(nib);
                    fld_phase  = afu_pkg::PH_ESC2;
                end
            end
            afu_pkg::PH_ESC2: begin
                // A non-hex second character is swallowed; keep the single digit
                if (nib < 0) store_byte({4'h0, fld_nibble});
                else         store_byte({fld_nibble, 4'(nib)});
            end
            afu_pkg::PH_SKIP: begin
                if (c == afu_pkg::CH_CLOSE) begin
                    fld_phase = afu_pkg::PH_IDLE;
                    push_result(afu_pkg::K_DONE, 8'h00, 1'b1);
                end
            end
            default: begin
                fld_phase = afu_pkg::PH_IDLE;
                if (c != afu_pkg::CH_OPEN) begin
                    fld_count = 8'd0;
                    push_result(afu_pkg::K_NOOPEN, 8'h00, 1'b1);
                end else begin
                    // Clamp capacity to 1..MAX_FIELD, taken at the brace only
                    lim = (cap == 8'd0) ? 1 : int'(cap);
                    if (lim > MAX_FIELD) lim = MAX_FIELD;
                    fld_limit  = 8'(lim);
                    fld_count  = 8'd0;
                    fld_nibble = 4'h0;
                    fld_phase  = (lim <= 1) ? afu_pkg::PH_SKIP : afu_pkg::PH_FIELD;
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_error(string msg);
        error_count++;
        if (error_count <= MAX_PRINTED_ERRORS) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
    endtask

    task automatic check_result(afu_pkg::t_out_item got);
        afu_pkg::t_out_item want;
        if (expected_results.size() == 0) begin
            report_error($sformatf("unexpected result item kind %0d byte %02h count %0d",
                                   got.kind, got.data_byte, got.byte_count));
        end else begin
            want = expected_results.pop_front();
            if (got.kind != want.kind)
                report_error($sformatf("kind: expected %0d got %0d", want.kind, got.kind));
            if (got.data_byte != want.data_byte)
                report_error($sformatf("data_byte: expected %02h got %02h",
                                       want.data_byte, got.data_byte));
            if (got.byte_count != want.byte_count)
                report_error($sformatf("byte_count: expected %0d got %0d",
                                       want.byte_count, got.byte_count));
            if (got.last != want.last)
                report_error($sformatf("last: expected %0b got %0b", want.last, got.last));
        end
        results_seen++;
        if (got.kind == afu_pkg::K_DONE) fields_done++;
        if (got.kind == afu_pkg::K_NOOPEN || got.kind == afu_pkg::K_BADHEX) field_errors++;
    endtask

    // Sample results at the rising edge; draw the stall for the next one
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            check_result(o_out_item);
            rx_wait = idle_on ? $urandom_range(0, 3) : 0;
        end
    end

    // Receiver: hold off for a long stretch when asked, else stall as drawn
    always @(negedge i_clk) begin
        if (stall_hold > 0) begin
            i_out_stall <= 1'b1;
            stall_hold--;
        end else if (rx_wait > 0) begin
            i_out_stall <= 1'b1;
            rx_wait--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offer one character item; predict it once the block accepts it.
    // Valid stays high into the next item when no gap is drawn.
    task automatic send_char(logic [7:0] c, logic [7:0] cap);
        int                gap;
        afu_pkg::t_in_item item;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        item.char_in  = c;
        item.capacity = cap;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_char(c, cap);
        sent_items++;
    endtask

    task automatic release_input();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    // Wait until every expected result item has arrived, with a bound.
    task automatic wait_drain(int max_cycles);
        int n;
        n = 0;
        while (expected_results.size() != 0 && n < max_cycles) begin
            @(posedge i_clk);
            n++;
        end
    endtask

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] nib);
        if (nib < 4'd10) return 8'h30 + 8'(nib);
        if ($urandom_range(0, 1) == 0) return 8'h41 + 8'(nib) - 8'd10;
        return 8'h61 + 8'(nib) - 8'd10;
    endfunction

    function automatic logic [7:0] non_hex_char();
        logic [7:0] c;
        do c = rand_byte(); while (hex_nibble(c) >= 0);
        return c;
    endfunction

    // Plain field character: anything but the close brace and backslash
    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do c = rand_byte(); while (c == afu_pkg::CH_CLOSE || c == afu_pkg::CH_BSLASH);
        return c;
    endfunction

    // Send one field with random content: mostly well formed, sometimes
    // broken by a bad first hex digit, which ends it early.
    task automatic send_random_field(int max_len);
        logic [7:0] cap;
        int         len;
        int         pick;
        int         k;
        cap = ($urandom_range(0, 9) == 0) ? rand_byte() : 8'($urandom_range(0, 12));
        send_char(afu_pkg::CH_OPEN, cap);
        len = $urandom_range(0, max_len);
        for (k = 0; k < len; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                send_char(plain_char(), rand_byte());
            end else if (pick < 60) begin
                send_char(afu_pkg::CH_BSLASH, rand_byte());
                send_char(afu_pkg::CH_BSLASH, rand_byte());
            end else if (pick < 85) begin
                send_char(afu_pkg::CH_BSLASH, rand_byte());
                send_char(hex_char(4'($urandom)), rand_byte());
                send_char(hex_char(4'($urandom)), rand_byte());
            end else if (pick < 96) begin
                // Single-digit escape; a close brace drawn here gets swallowed too
                send_char(afu_pkg::CH_BSLASH, rand_byte());
                send_char(hex_char(4'($urandom)), rand_byte());
                send_char(($urandom_range(0, 3) == 0) ? afu_pkg::CH_CLOSE
                                                      : non_hex_char(),
                          rand_byte());
            end else begin
                send_char(afu_pkg::CH_BSLASH, rand_byte());
                send_char(non_hex_char(), rand_byte());
                return;
            end
        end
        send_char(afu_pkg::CH_CLOSE, rand_byte());
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Characters outside a field are rejected one by one
    task automatic test_missing_brace();
        send_char(8'h78, 8'h00);
        send_char(8'hFF, 8'hFF);
    endtask

    // Capacity zero acts as one: nothing stored, skip to the close brace
    task automatic test_capacity_bounds();
        send_char(afu_pkg::CH_OPEN, 8'd0);
        send_char(8'h71, 8'hAA);
        send_char(afu_pkg::CH_CLOSE, 8'h55);
    endtask

    // Hex escapes in both cases, a swallowed close brace, extreme bytes
    task automatic test_escapes();
        send_char(afu_pkg::CH_OPEN, 8'd255);
        send_char(8'h00, 8'd0);
        send_char(8'hFF, 8'd0);
        send_char(afu_pkg::CH_BSLASH, 8'd0);
        send_char(8'h34, 8'd0);
        send_char(8'h66, 8'd0);
        send_char(afu_pkg::CH_BSLASH, 8'd0);
        send_char(8'h41, 8'd0);
        send_char(afu_pkg::CH_CLOSE, 8'd0);
        send_char(afu_pkg::CH_CLOSE, 8'd0);
    endtask

    // Limit of three keeps two bytes, then drops until the close brace
    task automatic test_overflow();
        send_char(afu_pkg::CH_OPEN, 8'd3);
        send_char(8'h41, 8'd0);
        send_char(afu_pkg::CH_BSLASH, 8'd0);
        send_char(afu_pkg::CH_BSLASH, 8'd0);
        send_char(8'h7A, 8'd0);
        send_char(afu_pkg::CH_CLOSE, 8'd0);
    endtask

    // A space after a backslash is no hex digit and aborts the field
    task automatic test_bad_hex();
        send_char(afu_pkg::CH_OPEN, 8'd255);
        send_char(afu_pkg::CH_BSLASH, 8'd0);
        send_char(8'h20, 8'd0);
    endtask

    // Fill a field of the largest capacity until it overflows
    task automatic test_max_capacity();
        int k;
        send_char(afu_pkg::CH_OPEN, 8'd255);
        for (k = 0; k < 260; k++) send_char(plain_char(), rand_byte());
        send_char(afu_pkg::CH_CLOSE, rand_byte());
    endtask

    // Hold off the receiver while the sender keeps offering items, so the
    // output buffer fills and the block stalls its input
    task automatic test_output_backpressure();
        int k;
        idle_on = 1'b0;
        stall_hold = 150;
        send_char(afu_pkg::CH_OPEN, 8'd255);
        for (k = 0; k < 30; k++) send_char(plain_char(), rand_byte());
        send_char(afu_pkg::CH_CLOSE, rand_byte());
        idle_on = 1'b1;
    endtask

    // Pause the sender until every result item has come back
    task automatic test_sender_pause();
        send_random_field(8);
        release_input();
        wait_drain(DRAIN_LIMIT);
        send_random_field(8);
    endtask

    // Random stream of fields and stray characters; drop idling now and then
    task automatic test_random_stream();
        int target;
        target = sent_items + RANDOM_ITEMS;
        while (sent_items < target) begin
            idle_on = ($urandom_range(0, 7) != 0);
            if ($urandom_range(0, 9) == 0) send_char(rand_byte(), rand_byte());
            else                           send_random_field(16);
        end
        idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin : main
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_out_stall = 1'b0;
        cycle_count = 0;
        error_count = 0;
        sent_items  = 0;
        results_seen = 0;
        fields_done  = 0;
        field_errors = 0;
        rx_wait     = 0;
        stall_hold  = 0;
        idle_on     = 1'b1;
        fld_phase   = afu_pkg::PH_IDLE;
        fld_nibble  = 4'h0;
        fld_count   = 8'd0;
        fld_limit   = 8'd0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_missing_brace();
        test_capacity_bounds();
        test_escapes();
        test_overflow();
        test_bad_hex();
        test_max_capacity();
        test_output_backpressure();
        test_sender_pause();
        test_random_stream();

        release_input();
        wait_drain(DRAIN_LIMIT);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            report_error($sformatf("%0d expected result items never arrived",
                                   expected_results.size()));
        end

        $display("Run covered %0d characters and %0d result items: %0d closed fields,",
                 sent_items, results_seen, fields_done);
        $display("%0d field errors, with random gaps, stalls and a long receiver hold-off.",
                 field_errors);
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[files.f]
rtl/afu_pkg.sv
rtl/afu_step.sv
rtl/ascii1_field_unescape_core.sv
tb/ascii1_field_unescape_core_tb.sv
